FILE: rtl/csct_pkg.sv
// Shared types and constants of the channel status change table.
// Used by csct_ctrl, csct_dp and channel_status_change_table; no dependencies.
package csct_pkg;

  localparam int unsigned ENTRIES_DEF           = 64;
  localparam logic [31:0] REPORT_INTERVAL_RESET = 32'd1800;  // 30 minutes
  localparam int unsigned CFG_ADDR_W            = 3;

  // Register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_REPORT_INTERVAL = '0;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CHG_NONE    = 2'd0,
    CHG_NEW     = 2'd1,
    CHG_REFRESH = 2'd2
  } chg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] channel_key;
    logic [7:0]  new_status;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] status_out;
    chg_t       change_code;
    logic       table_full;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  status;
    logic [31:0] report_time;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new transaction
    logic rd_en;     // issue a table read at the scan pointer
    logic scan_end;  // capture the match result
    logic commit;    // write back and present the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;         // registered read data matches the key
    logic issue_done;  // every used slot has been read
  } dp_stat_t;

endpackage

FILE: rtl/csct_ctrl.sv
// Scan controller of the channel status change table.
// Depends on csct_pkg; drives csct_dp through ctrl_cmd_t.
module csct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  csct_pkg::dp_stat_t   stat,
  output csct_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import csct_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.issue_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        // stop reading on a hit so the matching entry stays in the read register
        cmd.rd_en    = !stat.hit && !stat.issue_done;
        cmd.scan_end = stat.hit || stat.issue_done;
      end
      ST_FINISH: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/csct_dp.sv
// Datapath of the channel status change table: entry memory, scan pointer,
// key compare, update decision and result register. Depends on csct_pkg.
module csct_dp #(
  parameter int unsigned ENTRIES = csct_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csct_pkg::ctrl_cmd_t  cmd,
  output csct_pkg::dp_stat_t   stat,
  input  csct_pkg::in_item_t   in_item,
  input  logic [31:0]          report_interval,
  output logic                 out_valid,
  output csct_pkg::out_item_t  out_item
);
  import csct_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  entry_t           mem [ENTRIES];

  in_item_t         req_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] used_nxt;
  logic [CNT_W-1:0] scan_r;
  entry_t           rdata_r;
  logic             rd_valid_r;
  logic [IDX_W-1:0] rd_slot_r;
  logic             match_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             hit;
  logic             tbl_full;
  logic [31:0]      age;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  out_item_t        res;

  assign hit             = rd_valid_r && (rdata_r.key == req_r.channel_key);
  assign stat.hit        = hit;
  assign stat.issue_done = (scan_r == used_r);

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r   <= mem[scan_r[IDX_W-1:0]];
      rd_slot_r <= scan_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.scan_end) begin
      match_r <= hit;
    end
    if (cmd.commit) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      scan_r      <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      rd_valid_r  <= cmd.rd_en;
      out_valid_r <= cmd.commit;
      if (cmd.load) begin
        scan_r <= '0;
      end else if (cmd.rd_en) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  // Decide the outcome from the scan result
  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    wr_addr  = rd_slot_r;
    wr_data  = rdata_r;
    used_nxt = used_r;
    tbl_full = (used_r == CNT_W'(ENTRIES));
    age      = req_r.now_seconds - rdata_r.report_time;
    if (req_r.command == CMD_LOOKUP) begin
      res.found = match_r;
      if (match_r) begin
        res.status_out = rdata_r.status;
      end
    end else if (match_r) begin
      res.found = 1'b1;
      if (rdata_r.status != req_r.new_status) begin
        res.change_code = CHG_NEW;
      end else if (age > report_interval) begin
        res.change_code = CHG_REFRESH;
      end
      wr_en          = cmd.commit;
      wr_data.status = req_r.new_status;
      if (res.change_code != CHG_NONE) begin
        wr_data.report_time = req_r.now_seconds;
      end
    end else if (!tbl_full) begin
      res.change_code     = CHG_NEW;
      wr_en               = cmd.commit;
      wr_addr             = used_r[IDX_W-1:0];
      wr_data.key         = req_r.channel_key;
      wr_data.status      = req_r.new_status;
      wr_data.report_time = req_r.now_seconds;
      if (cmd.commit) begin
        used_nxt = used_r + 1'b1;
      end
    end else begin
      res.table_full = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/channel_status_change_table.sv
// Channel status change table, top level: APB-style register, scan controller
// and datapath. Depends on csct_pkg, csct_ctrl and csct_dp.
//
// A transaction is accepted when start is high and busy is low. The block
// then reads its entries one per clock from the single read port of the
// entry memory, in slot order, stopping at the first key match; that scan
// loop sets the rate. busy stays high through the scan state and the finish
// state that follows it. The result appears on out_item with out_valid
// high for exactly one cycle, in the first cycle with busy low again, so
// the next transaction can be started there. The receiver cannot stall:
// take out_item whenever out_valid is high. An update reports change_code 1
// on a changed or new status and 2 when the status is unchanged but the
// last report is older than report_interval (age taken modulo 2^32); any
// report stamps the entry with now_seconds. A new key into a full table is
// refused with table_full. report_interval lives at byte address 0 and resets
// to 1800; it must be written only while the block is idle, which the block
// itself does not enforce. The table needs no clearing after reset.
module channel_status_change_table #(
  parameter int unsigned ENTRIES = csct_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  csct_pkg::in_item_t              in_item,
  // result channel
  output logic                            out_valid,
  output csct_pkg::out_item_t             out_item,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csct_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import csct_pkg::*;

  logic        [31:0] report_interval_r;
  logic               cfg_wr;
  logic               cfg_sel_ri;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  // Register file: a single register, everything else reads zero and
  // drops writes
  assign pready     = 1'b1;
  assign cfg_sel_ri = (paddr[CFG_ADDR_W-1:2] == REG_REPORT_INTERVAL);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = cfg_sel_ri ? report_interval_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_interval_r <= REPORT_INTERVAL_RESET;
    end else if (cfg_wr && cfg_sel_ri) begin
      report_interval_r <= pwdata;
    end
  end

  csct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  csct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_item         (in_item),
    .report_interval (report_interval_r),
    .out_valid       (out_valid),
    .out_item        (out_item)
  );

  // An accepted transaction holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result ends the transaction: busy is low while it is shown
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // A refused insert reports nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.table_full) |->
      (!out_item.found && out_item.change_code == CHG_NONE))
    else $error("refused insert with found or change set");

  // A returned status only comes from a lookup hit, which never reports
  a_status_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status_out != 8'd0) |->
      (out_item.found && out_item.change_code == CHG_NONE && !out_item.table_full))
    else $error("status returned outside a lookup hit");

endmodule
